// ----- design/bmp_pkg.sv -----
// Package for the BMP stream parser: constants, codes and transfer payload types.
package bmp_pkg;

	// Largest supported image dimension is 2**DIM_BITS - 1.
	localparam int DIM_BITS = 16;
	localparam int COL_W = DIM_BITS + 2;

	localparam logic [15:0] MAGIC_BM = 16'h4D42;
	localparam logic [6:0] FILE_HDR_LEN = 7'd14;
	localparam logic [31:0] INFO_SMALL = 32'd12;
	localparam logic [31:0] INFO_MID = 32'd40;
	localparam logic [31:0] INFO_LARGE = 32'd64;
	localparam logic [31:0] MAP_FULL = 32'd256;
	localparam logic [15:0] DEPTH_INDEXED = 16'd8;
	localparam logic [15:0] DEPTH_BGR = 16'd24;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_TRUNCATED = 3'd1,
		ERR_BAD_MAGIC = 3'd2,
		ERR_INVALID = 3'd3,
		ERR_UNSUPPORTED = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic frame_start;
		logic stream_end;
	} src_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [2:0] error_code;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [4:0] bits_per_pixel;
		logic signed [31:0] x_resolution;
		logic signed [31:0] y_resolution;
		logic [7:0] pixel_byte;
		logic [15:0] image_row;
		logic [17:0] byte_in_row;
		logic last_of_image;
	} res_item_t;

endpackage

// ----- design/bmp_stream_header_and_row_parser.sv -----
// Top level of the BMP stream parser: header decode, skip and row unpacking.
//
// The block takes one BMP file byte per transfer and returns at most one result per byte:
// one header result after the info header, colour map and offset gap, then one result
// per pixel byte with its destination row (bottom-up) and position in the row, with the
// 4-byte row padding dropped; errors end the file. Each byte passes through the input
// register and then the result register, so a byte can be accepted in every cycle unless
// the result register is stalled. All field decoding, the colour map and offset checks
// and the row counters are updated in a single stage between the two registers.
module bmp_stream_header_and_row_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  bmp_pkg::src_item_t     src_item,
	output logic                   res_valid,
	input  logic                   res_stall,
	output bmp_pkg::res_item_t     res_item
);
	import bmp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HDR,
		PH_SKIP,
		PH_PIX
	} phase_t;

	// Input register and parse state.
	logic          valid_s1;
	src_item_t     item_s1;
	phase_t        phase_q, n_phase;
	logic [6:0]    pos_q, n_pos;
	logic [31:0]   offset_q, n_offset;
	logic [31:0]   info_q, n_info;
	logic [31:0]   width_q, n_width;
	logic [31:0]   height_q, n_height;
	logic [15:0]   depth_q, n_depth;
	logic [31:0]   comp_q, n_comp;
	logic [31:0]   xres_q, n_xres;
	logic [31:0]   yres_q, n_yres;
	logic [31:0]   colors_q, n_colors;
	logic [31:0]   skip_q, n_skip;
	logic [COL_W-1:0]    col_q, n_col;
	logic [DIM_BITS-1:0] rows_q, n_rows;
	logic          res_valid_q;
	res_item_t     res_q;

	logic          blocked, go, emit, err, do_finish, start;
	err_t          err_code;
	res_item_t     r;
	phase_t        ph;
	logic [6:0]    rel;
	logic [8:0]    clr;
	logic [10:0]   need;
	logic signed [33:0] pad;
	logic [COL_W-1:0] rs, stride, c1;

	assign blocked = res_valid_q && res_stall;
	assign go = valid_s1 && !blocked;
	assign src_stall = valid_s1 && blocked;
	assign res_valid = res_valid_q;
	assign res_item = res_q;
	assign start = item_s1.frame_start;

	// Row geometry of the current image.
	always_comb begin
		rs = COL_W'(width_q[DIM_BITS-1:0]);
		if (depth_q == DEPTH_BGR) begin
			rs = rs + COL_W'({width_q[DIM_BITS-1:0], 1'b0});
		end
		stride = (rs + COL_W'(3)) & ~COL_W'(3);
		c1 = col_q + COL_W'(1);
	end

	// Next state and result for the byte in the input register.
	always_comb begin
		ph = start ? PH_HDR : phase_q;
		n_phase = ph;
		n_pos = start ? '0 : pos_q;
		n_offset = start ? '0 : offset_q;
		n_info = start ? '0 : info_q;
		n_width = start ? '0 : width_q;
		n_height = start ? '0 : height_q;
		n_depth = start ? '0 : depth_q;
		n_comp = start ? '0 : comp_q;
		n_xres = start ? '0 : xres_q;
		n_yres = start ? '0 : yres_q;
		n_colors = start ? '0 : colors_q;
		n_skip = start ? '0 : skip_q;
		n_col = start ? '0 : col_q;
		n_rows = start ? '0 : rows_q;
		emit = 1'b0;
		err = 1'b0;
		err_code = ERR_NONE;
		do_finish = 1'b0;
		r = '0;
		rel = n_pos - FILE_HDR_LEN;
		clr = '0;
		need = '0;
		pad = '0;

		if (item_s1.stream_end) begin
			if (ph != PH_IDLE) begin
				err = 1'b1;
				err_code = ERR_TRUNCATED;
			end
		end else begin
			case (ph)
				PH_HDR: begin
					n_pos = n_pos + 7'd1;
					if (n_pos - 7'd1 < FILE_HDR_LEN) begin
						// File header: magic in the depth field, then the data offset.
						case (rel + FILE_HDR_LEN)
							7'd0: n_depth[7:0] = item_s1.byte_value;
							7'd1: n_depth[15:8] = item_s1.byte_value;
							7'd10: n_offset[7:0] = item_s1.byte_value;
							7'd11: n_offset[15:8] = item_s1.byte_value;
							7'd12: n_offset[23:16] = item_s1.byte_value;
							7'd13: n_offset[31:24] = item_s1.byte_value;
							default: ;
						endcase
						if (rel + FILE_HDR_LEN == FILE_HDR_LEN - 7'd1) begin
							if (n_depth != MAGIC_BM) begin
								err = 1'b1;
								err_code = ERR_BAD_MAGIC;
							end else begin
								n_depth = '0;
							end
						end
					end else if (rel < 7'd4) begin
						n_info[8*rel[1:0] +: 8] = item_s1.byte_value;
						if (rel == 7'd3 && (n_info < INFO_SMALL || n_info > INFO_LARGE)) begin
							err = 1'b1;
							err_code = ERR_INVALID;
						end
					end else begin
						// Info header fields, layout set by the header size.
						if (n_info == INFO_SMALL) begin
							if (rel >= 7'd4 && rel < 7'd6)
								n_width[8*rel[0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd6 && rel < 7'd8)
								n_height[8*rel[0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd10 && rel < 7'd12)
								n_depth[8*rel[0] +: 8] = item_s1.byte_value;
						end else begin
							if (rel >= 7'd4 && rel < 7'd8)
								n_width[8*rel[1:0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd8 && rel < 7'd12)
								n_height[8*rel[1:0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd14 && rel < 7'd16)
								n_depth[8*rel[0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd16 && rel < 7'd20)
								n_comp[8*rel[1:0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd24 && rel < 7'd28)
								n_xres[8*rel[1:0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd28 && rel < 7'd32)
								n_yres[8*rel[1:0] +: 8] = item_s1.byte_value;
							if (rel >= 7'd32 && rel < 7'd36)
								n_colors[8*rel[1:0] +: 8] = item_s1.byte_value;
						end
						if (32'(rel) + 32'd1 >= n_info) begin
							// End of info header: size, compression, colour map and offset.
							pad = $signed({{2{n_offset[31]}}, n_offset})
								- $signed(34'(n_info) + 34'(FILE_HDR_LEN));
							if (n_depth == DEPTH_INDEXED) begin
								if (n_colors[31] || n_colors == '0) begin
									clr = 9'(MAP_FULL);
								end else begin
									clr = n_colors[8:0];
								end
								need = (n_info == INFO_SMALL)
									? 11'(clr) + {1'b0, clr, 1'b0}
									: {clr, 2'b00};
							end
							if (n_info != INFO_SMALL && n_info != INFO_MID
								&& n_info != INFO_LARGE) begin
								err = 1'b1;
								err_code = ERR_INVALID;
							end else if (n_info != INFO_SMALL && n_comp != '0) begin
								err = 1'b1;
								err_code = ERR_UNSUPPORTED;
							end else if (n_depth == DEPTH_INDEXED && !n_colors[31]
								&& n_colors > MAP_FULL) begin
								err = 1'b1;
								err_code = ERR_INVALID;
							end else if (pad < $signed({23'b0, need})) begin
								err = 1'b1;
								err_code = ERR_INVALID;
							end else begin
								n_skip = pad[31:0];
								if (pad == '0) begin
									do_finish = 1'b1;
								end else begin
									n_phase = PH_SKIP;
								end
							end
						end
					end
				end
				PH_SKIP: begin
					n_skip = n_skip - 32'd1;
					if (n_skip == '0) begin
						do_finish = 1'b1;
					end
				end
				PH_PIX: begin
					// Pixel bytes of the row, then its padding.
					if (col_q < rs) begin
						emit = 1'b1;
						r.result_kind = KIND_PIXEL;
						r.pixel_byte = item_s1.byte_value;
						r.image_row = 16'(rows_q - DIM_BITS'(1));
						r.byte_in_row = 18'(col_q);
						r.last_of_image = (rows_q == DIM_BITS'(1)) && (c1 == rs);
					end
					n_col = c1;
					if (c1 >= stride) begin
						n_col = '0;
						n_rows = rows_q - DIM_BITS'(1);
						if (rows_q == DIM_BITS'(1)) begin
							n_phase = PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end

		// Header result, or a depth or size error, at the start of the pixel data.
		if (do_finish) begin
			if (n_depth != DEPTH_INDEXED && n_depth != DEPTH_BGR) begin
				err = 1'b1;
				err_code = ERR_UNSUPPORTED;
			end else if ((|n_width[31:DIM_BITS]) || (|n_height[31:DIM_BITS])) begin
				err = 1'b1;
				err_code = ERR_INVALID;
			end else begin
				emit = 1'b1;
				r.result_kind = KIND_HEADER;
				r.image_width = 16'(n_width[DIM_BITS-1:0]);
				r.image_height = 16'(n_height[DIM_BITS-1:0]);
				r.bits_per_pixel = n_depth[4:0];
				r.x_resolution = $signed(n_xres);
				r.y_resolution = $signed(n_yres);
				if (n_width == '0 || n_height == '0) begin
					r.last_of_image = 1'b1;
					n_phase = PH_IDLE;
				end else begin
					n_col = '0;
					n_rows = n_height[DIM_BITS-1:0];
					n_phase = PH_PIX;
				end
			end
		end

		if (err) begin
			emit = 1'b1;
			r = '0;
			r.result_kind = KIND_ERROR;
			r.error_code = err_code;
			n_phase = PH_IDLE;
		end
	end

	// Input register, parse state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q <= PH_IDLE;
			pos_q <= '0;
			offset_q <= '0;
			info_q <= '0;
			width_q <= '0;
			height_q <= '0;
			depth_q <= '0;
			comp_q <= '0;
			xres_q <= '0;
			yres_q <= '0;
			colors_q <= '0;
			skip_q <= '0;
			col_q <= '0;
			rows_q <= '0;
		end else begin
			if (!src_stall) begin
				valid_s1 <= src_valid;
				if (src_valid) begin
					item_s1 <= src_item;
				end
			end
			if (go) begin
				res_valid_q <= emit;
				if (emit) begin
					res_q <= r;
				end
				phase_q <= n_phase;
				pos_q <= n_pos;
				offset_q <= n_offset;
				info_q <= n_info;
				width_q <= n_width;
				height_q <= n_height;
				depth_q <= n_depth;
				comp_q <= n_comp;
				xres_q <= n_xres;
				yres_q <= n_yres;
				colors_q <= n_colors;
				skip_q <= n_skip;
				col_q <= n_col;
				rows_q <= n_rows;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// Pixel phase always has a row left to deliver.
	a_rows_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIX |-> rows_q != '0)
		else $error("pixel phase with no rows left");

	// Column counter stays inside the padded row.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIX |-> col_q < stride)
		else $error("column counter beyond row stride");

	// Skip phase always has bytes left to skip.
	a_skip_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("skip phase with zero count");

	// A processed byte that gives no result leaves the result register empty.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		go && !emit |=> !res_valid)
		else $error("result shown for a byte without result");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the BMP stream parser: directed and random files checked against a predictor.
module tb;
	import bmp_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int ITEM_TARGET = 1150;
	localparam int QUIET_FROM = 1080;
	localparam int HOLD_CYCLES = 200;
	localparam int PH_IDLE = 0;
	localparam int PH_HDR = 1;
	localparam int PH_SKIP = 2;
	localparam int PH_PIX = 3;

	logic clk = 1'b0;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	src_item_t src_item;
	logic res_valid;
	logic res_stall;
	res_item_t res_item;

	bmp_stream_header_and_row_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
		.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
	);

	// Parser state of the predictor.
	int unsigned p_phase, p_pos, p_offset, p_info, p_w, p_h, p_depth, p_comp;
	int unsigned p_xres, p_yres, p_colors, p_skip, p_col, p_rows;

	res_item_t expected_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	bit quiet_mode;
	bit hold_req;
	bit hold_done = 1'b0;
	int hold_count = 0;
	int stall_left = 0;
	byte unsigned file_bytes[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_parser();
		p_phase = PH_IDLE; p_pos = 0; p_offset = 0; p_info = 0; p_w = 0; p_h = 0;
		p_depth = 0; p_comp = 0; p_xres = 0; p_yres = 0; p_colors = 0; p_skip = 0;
		p_col = 0; p_rows = 0;
	endfunction

	function automatic void push_error(err_t code);
		res_item_t r;
		r = '0;
		r.result_kind = KIND_ERROR;
		r.error_code = code;
		expected_results.push_back(r);
		p_phase = PH_IDLE;
	endfunction

	function automatic void place(ref int unsigned field, input int unsigned rel,
			input int unsigned first, input int unsigned len, input int unsigned b);
		if (rel >= first && rel < first + len)
			field = field | (b << (8 * (rel - first)));
	endfunction

	function automatic void emit_header();
		res_item_t r;
		if (p_depth != 8 && p_depth != 24) begin
			push_error(ERR_UNSUPPORTED);
			return;
		end
		if (p_w >= (1 << DIM_BITS) || p_h >= (1 << DIM_BITS)) begin
			push_error(ERR_INVALID);
			return;
		end
		r = '0;
		r.result_kind = KIND_HEADER;
		r.image_width = p_w[15:0];
		r.image_height = p_h[15:0];
		r.bits_per_pixel = p_depth[4:0];
		r.x_resolution = p_xres;
		r.y_resolution = p_yres;
		if (p_w == 0 || p_h == 0) begin
			r.last_of_image = 1'b1;
			p_phase = PH_IDLE;
		end else begin
			p_col = 0;
			p_rows = p_h;
			p_phase = PH_PIX;
		end
		expected_results.push_back(r);
	endfunction

	function automatic void close_info();
		longint pad, clr, entry;
		clr = 0;
		entry = 0;
		if (p_info != 12 && p_info != 40 && p_info != 64) begin
			push_error(ERR_INVALID);
			return;
		end
		if (p_info != 12 && p_comp != 0) begin
			push_error(ERR_UNSUPPORTED);
			return;
		end
		pad = longint'($signed(p_offset)) - longint'(p_info + 14);
		if (p_depth == 8) begin
			entry = (p_info == 12) ? 3 : 4;
			clr = longint'($signed(p_colors));
			if (clr <= 0)
				clr = 256;
			else if (clr > 256) begin
				push_error(ERR_INVALID);
				return;
			end
		end
		if (pad - clr * entry < 0) begin
			push_error(ERR_INVALID);
			return;
		end
		p_skip = pad[31:0];
		if (p_skip == 0)
			emit_header();
		else
			p_phase = PH_SKIP;
	endfunction

	function automatic void header_step(int unsigned b);
		int unsigned pos, rel;
		pos = p_pos;
		p_pos = (pos + 1) & 7'h7F;
		if (pos < 14) begin
			place(p_depth, pos, 0, 2, b);
			place(p_offset, pos, 10, 4, b);
			if (pos == 13) begin
				if (p_depth != 32'h4D42) begin
					push_error(ERR_BAD_MAGIC);
					return;
				end
				p_depth = 0;
			end
			return;
		end
		rel = pos - 14;
		if (rel < 4) begin
			place(p_info, rel, 0, 4, b);
			if (rel == 3 && (p_info < 12 || p_info > 64))
				push_error(ERR_INVALID);
			return;
		end
		if (p_info == 12) begin
			place(p_w, rel, 4, 2, b);
			place(p_h, rel, 6, 2, b);
			place(p_depth, rel, 10, 2, b);
		end else begin
			place(p_w, rel, 4, 4, b);
			place(p_h, rel, 8, 4, b);
			place(p_depth, rel, 14, 2, b);
			place(p_comp, rel, 16, 4, b);
			place(p_xres, rel, 24, 4, b);
			place(p_yres, rel, 28, 4, b);
			place(p_colors, rel, 32, 4, b);
		end
		if (rel + 1 >= p_info)
			close_info();
	endfunction

	function automatic void pixel_step(int unsigned b);
		longint unsigned rs, stride, c;
		res_item_t r;
		rs = longint'(p_w) * ((p_depth == 24) ? 3 : 1);
		stride = (rs + 3) & ~64'd3;
		c = p_col;
		if (c < rs) begin
			r = '0;
			r.result_kind = KIND_PIXEL;
			r.pixel_byte = b[7:0];
			r.image_row = 16'(p_rows - 1);
			r.byte_in_row = c[17:0];
			r.last_of_image = (p_rows == 1 && c + 1 == rs);
			expected_results.push_back(r);
		end
		c++;
		if (c >= stride) begin
			c = 0;
			p_rows--;
			if (p_rows == 0)
				p_phase = PH_IDLE;
		end
		p_col = c[31:0];
	endfunction

	// Advance the predictor by one accepted input transfer.
	function automatic void predict_byte(src_item_t it);
		if (it.frame_start) begin
			clear_parser();
			p_phase = PH_HDR;
		end
		if (it.stream_end) begin
			if (p_phase != PH_IDLE)
				push_error(ERR_TRUNCATED);
			return;
		end
		case (p_phase)
			PH_HDR: header_step(it.byte_value);
			PH_SKIP: begin
				p_skip--;
				if (p_skip == 0)
					emit_header();
			end
			PH_PIX: pixel_step(it.byte_value);
			default: ;
		endcase
	endfunction

	// Drive one item and wait for its transfer, with optional random gaps first.
	task automatic send_byte(logic [7:0] b, logic fs, logic se);
		src_item_t it;
		int gap;
		if (!quiet_mode && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			src_valid <= 1'b0;
			src_item <= src_item_t'(10'($urandom));
			repeat (gap) @(posedge clk);
		end
		it.byte_value = b;
		it.frame_start = fs;
		it.stream_end = se;
		src_valid <= 1'b1;
		src_item <= it;
		do @(posedge clk); while (src_stall);
		predict_byte(it);
		items_sent++;
	endtask

	task automatic send_file(bit truncate, int unsigned cut);
		int n;
		n = file_bytes.size();
		if (truncate && cut < n)
			n = cut;
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], i == 0, 1'b0);
		if (truncate)
			send_byte(8'($urandom), n == 0, 1'b1);
	endtask

	function automatic void put_le(int unsigned v, int len);
		for (int i = 0; i < len; i++)
			file_bytes.push_back(8'((v >> (8 * i)) & 8'hFF));
	endfunction

	// Build a file into file_bytes; pad is the gap after headers and colour map.
	// A colour count above 256 is rejected before the map, so no map is written then.
	function automatic void build_file(int unsigned info, int unsigned w, int unsigned h,
			int unsigned depth, int unsigned comp, int unsigned colors, int unsigned pad,
			bit bad_magic);
		int unsigned entry, ncol, offs, rs;
		entry = (info == 12) ? 3 : 4;
		ncol = 0;
		if (depth == 8) begin
			if ($signed(colors) <= 0)
				ncol = 256;
			else if (colors <= 256)
				ncol = colors;
		end
		offs = 14 + info + ncol * entry + pad;
		file_bytes.delete();
		put_le(bad_magic ? 32'h4D43 : 32'h4D42, 2);
		put_le($urandom, 4);
		put_le($urandom, 4);
		put_le(offs, 4);
		put_le(info, 4);
		if (info == 12) begin
			put_le(w, 2); put_le(h, 2); put_le(1, 2); put_le(depth, 2);
		end else begin
			put_le(w, 4); put_le(h, 4); put_le(1, 2); put_le(depth, 2);
			put_le(comp, 4); put_le($urandom, 4);
			put_le($urandom, 4); put_le($urandom, 4);
			put_le(colors, 4); put_le($urandom, 4);
			for (int i = 40; i < info; i++)
				put_le($urandom, 1);
		end
		for (int i = 0; i < ncol * entry + pad; i++)
			put_le($urandom, 1);
		rs = w * ((depth == 24) ? 3 : 1);
		rs = (rs + 3) & ~32'd3;
		if (w < 64 && h < 64)
			for (int i = 0; i < rs * h; i++)
				put_le($urandom, 1);
	endfunction

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		res_item_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %p", res_item);
			end else begin
				exp_r = expected_results.pop_front();
				if (res_item !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p actual %p", exp_r, res_item);
				end
			end
		end
	end

	// Receiver stall: one long hold on request, else random bursts outside quiet mode.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_req && !hold_done) begin
			res_stall <= 1'b1;
			hold_count <= hold_count + 1;
			if (hold_count >= HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else if (quiet_mode) begin
			res_stall <= 1'b0;
		end else if (stall_left != 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic test_directed();
		build_file(40, 3, 2, 24, 0, 0, 0, 0);
		send_file(0, 0);
		build_file(12, 5, 3, 8, 0, 3, 2, 0);
		send_file(0, 0);
		build_file(64, 2, 2, 8, 0, 4, 1, 0);
		send_file(0, 0);
		build_file(40, 0, 4, 24, 0, 0, 0, 0);
		send_file(0, 0);
		build_file(40, 2, 2, 16, 0, 0, 0, 0);
		send_file(0, 0);
		build_file(40, 2, 2, 24, 1, 0, 0, 0);
		send_file(0, 0);
		build_file(40, 70000, 1, 24, 0, 0, 0, 0);
		send_file(0, 0);
		build_file(40, 65535, 65535, 24, 0, 0, 0, 0);
		send_file(0, 40);
		// Bad magic is reported after the file header; the rest is ignored.
		build_file(40, 1, 1, 24, 0, 0, 0, 1);
		send_file(1, 14);
		build_file(40, 1, 1, 8, 0, 300, 0, 0);
		send_file(0, 0);
		build_file(40, 1, 2, 24, 0, 0, 0, 0);
		send_file(1, 5);
		send_file(1, file_bytes.size() - 1);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0);
		// Info size out of range, odd size, and a negative pad.
		build_file(40, 1, 1, 24, 0, 0, 0, 0);
		file_bytes[14] = 8'd8;
		send_file(1, 18);
		file_bytes[14] = 8'd200;
		send_file(1, 18);
		build_file(40, 1, 1, 24, 0, 0, 0, 0);
		file_bytes[14] = 8'd20;
		send_file(1, 34);
		build_file(40, 1, 1, 24, 0, 0, 0, 0);
		file_bytes[10] = 8'd3;
		send_file(0, 0);
		// A zero or negative colour count means a full map, which the offset cannot hold.
		build_file(40, 1, 1, 8, 0, 1, 0, 0);
		for (int i = 46; i < 50; i++)
			file_bytes[i] = 8'h00;
		send_file(1, 54);
		for (int i = 46; i < 50; i++)
			file_bytes[i] = 8'hFF;
		send_file(1, 54);
	endtask

	task automatic test_backpressure();
		build_file(40, 2, 3, 24, 0, 0, 0, 0);
		hold_req = 1'b1;
		send_file(0, 0);
	endtask

	task automatic test_random();
		int unsigned sel, info, depth, w, h;
		while (items_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 9);
			info = (sel < 4) ? 40 : (sel < 7) ? 12 : 64;
			depth = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) :
				($urandom_range(0, 1) ? 8 : 24);
			w = $urandom_range(0, 6);
			h = $urandom_range(0, 3);
			build_file(info, w, h, depth,
				($urandom_range(0, 15) == 0) ? $urandom : 0,
				($urandom_range(0, 7) == 0) ? $urandom_range(257, 400) :
				$urandom_range(1, 8),
				$urandom_range(0, 3), $urandom_range(0, 20) == 0);
			if (items_sent > QUIET_FROM)
				quiet_mode = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				send_file(1, $urandom_range(0, file_bytes.size()));
			end else begin
				send_file(0, 0);
				if ($urandom_range(0, 5) == 0)
					send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 7) == 0)
				send_byte(8'($urandom), 1'b0, 1'b0);
		end
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		quiet_mode = 1'b0;
		hold_req = 1'b0;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		src_valid <= 1'b0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
design/bmp_pkg.sv
design/bmp_stream_header_and_row_parser.sv
tb/sv/tb.sv
